>>> rtl/status_led_blink_sequencer_macros.svh
// Assertion helpers used by the checker file.
`ifndef STATUS_LED_BLINK_SEQUENCER_MACROS_SVH
`define STATUS_LED_BLINK_SEQUENCER_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define SLBS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define SLBS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/slbs_pkg.sv
package slbs_pkg;

	localparam int TICK_W  = 16;
	localparam int HALF_W  = 16;
	localparam int BLINK_W = 4;
	localparam int CMP_W   = (TICK_W > HALF_W) ? TICK_W : HALF_W;
	localparam int CFG_W   = 16;

	localparam logic [TICK_W-1:0]  TICK_MAX  = '1;
	localparam logic [BLINK_W-1:0] BLINK_MAX = '1;

	// mode codes as seen on the ports
	localparam logic [2:0] MODE_IDLE    = 3'd0;
	localparam logic [2:0] MODE_SYNC    = 3'd1;
	localparam logic [2:0] MODE_UNCONF  = 3'd2;
	localparam logic [2:0] MODE_SUCCESS = 3'd3;
	localparam logic [2:0] MODE_ERROR   = 3'd4;
	localparam logic [2:0] MODE_CONFIG  = 3'd5;

	// register indexes on the config port
	localparam logic [2:0] REG_LED_ENABLED    = 3'd0;
	localparam logic [2:0] REG_BRIGHTNESS     = 3'd1;
	localparam logic [2:0] REG_SYNC_HALF      = 3'd2;
	localparam logic [2:0] REG_SUCCESS_HALF   = 3'd3;
	localparam logic [2:0] REG_ERROR_HALF     = 3'd4;
	localparam logic [2:0] REG_CONFIG_HALF    = 3'd5;
	localparam logic [2:0] REG_SUCCESS_BLINKS = 3'd6;
	localparam logic [2:0] REG_ERROR_BLINKS   = 3'd7;

	localparam logic [23:0] RGB_OFF    = 24'h000000;
	localparam logic [23:0] RGB_ORANGE = 24'hFF8000;
	localparam logic [23:0] RGB_YELLOW = 24'hFFFF00;
	localparam logic [23:0] RGB_GREEN  = 24'h00FF00;
	localparam logic [23:0] RGB_RED    = 24'hFF0000;
	localparam logic [23:0] RGB_WHITE  = 24'hFFFFFF;

	typedef enum logic [5:0] {
		ST_IDLE    = 6'b000001,
		ST_SYNC    = 6'b000010,
		ST_UNCONF  = 6'b000100,
		ST_SUCCESS = 6'b001000,
		ST_ERROR   = 6'b010000,
		ST_CONFIG  = 6'b100000
	} mode_t;

	typedef struct packed {
		logic       action;
		logic [2:0] requested_mode;
	} req_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       color_written;
		logic [2:0] current_mode;
	} rsp_t;

	typedef struct packed {
		logic               led_enabled;
		logic [7:0]         brightness;
		logic [HALF_W-1:0]  sync_half_period;
		logic [HALF_W-1:0]  success_half_period;
		logic [HALF_W-1:0]  error_half_period;
		logic [HALF_W-1:0]  config_half_period;
		logic [BLINK_W-1:0] success_blinks;
		logic [BLINK_W-1:0] error_blinks;
	} cfg_t;

	function automatic logic [2:0] mode_code(input mode_t m);
		logic [2:0] c;
		unique case (m)
			ST_SYNC:    c = MODE_SYNC;
			ST_UNCONF:  c = MODE_UNCONF;
			ST_SUCCESS: c = MODE_SUCCESS;
			ST_ERROR:   c = MODE_ERROR;
			ST_CONFIG:  c = MODE_CONFIG;
			default:    c = MODE_IDLE;
		endcase
		return c;
	endfunction

	// codes above config map to idle; callers filter them first
	function automatic mode_t mode_decode(input logic [2:0] c);
		mode_t m;
		unique case (c)
			MODE_SYNC:    m = ST_SYNC;
			MODE_UNCONF:  m = ST_UNCONF;
			MODE_SUCCESS: m = ST_SUCCESS;
			MODE_ERROR:   m = ST_ERROR;
			MODE_CONFIG:  m = ST_CONFIG;
			default:      m = ST_IDLE;
		endcase
		return m;
	endfunction

	function automatic logic [23:0] mode_rgb(input mode_t m);
		logic [23:0] rgb;
		unique case (m)
			ST_SYNC:    rgb = RGB_ORANGE;
			ST_UNCONF:  rgb = RGB_YELLOW;
			ST_SUCCESS: rgb = RGB_GREEN;
			ST_ERROR:   rgb = RGB_RED;
			ST_CONFIG:  rgb = RGB_WHITE;
			default:    rgb = RGB_OFF;
		endcase
		return rgb;
	endfunction

	// c*b/255 rounded down: prod>>8 is low by at most one, fixed by the remainder
	function automatic logic [7:0] scale_ch(input logic [7:0] c, input logic [7:0] b);
		logic [15:0] prod;
		logic [7:0]  q;
		logic [15:0] r;
		prod = {8'd0, c} * {8'd0, b};
		q    = prod[15:8];
		r    = prod - ({8'd0, q} * 16'd255);
		if (r >= 16'd255) begin
			q = q + 8'd1;
		end
		return q;
	endfunction

	function automatic logic [23:0] scale_rgb(input logic [23:0] rgb, input logic [7:0] b);
		return {scale_ch(rgb[23:16], b), scale_ch(rgb[15:8], b), scale_ch(rgb[7:0], b)};
	endfunction

endpackage

>>> rtl/slbs_core.sv
module slbs_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           fire,
	input  slbs_pkg::req_t req,
	input  slbs_pkg::cfg_t cfg,
	output slbs_pkg::rsp_t rsp
);

	slbs_pkg::mode_t                   mode_q, mode_n, req_mode;
	logic [slbs_pkg::TICK_W-1:0]       elapsed_q, elapsed_n, inc_cnt;
	logic                              phase_q, phase_n;
	logic [slbs_pkg::BLINK_W-1:0]      opc_q, opc_n, limit;
	logic [23:0]                       color_q, color_n;
	logic [slbs_pkg::HALF_W-1:0]       half;
	logic                              counted, blinking, written;

	assign req_mode = slbs_pkg::mode_decode(req.requested_mode);
	assign inc_cnt  = (elapsed_q == slbs_pkg::TICK_MAX) ? elapsed_q : elapsed_q + 1'b1;

	always_comb begin
		mode_n    = mode_q;
		elapsed_n = elapsed_q;
		phase_n   = phase_q;
		opc_n     = opc_q;
		color_n   = color_q;
		written   = 1'b0;
		half      = '0;
		limit     = '0;
		counted   = 1'b0;
		blinking  = 1'b0;

		unique case (mode_q)
			slbs_pkg::ST_SYNC: begin
				blinking = 1'b1;
				half     = cfg.sync_half_period;
			end
			slbs_pkg::ST_SUCCESS: begin
				blinking = 1'b1;
				counted  = 1'b1;
				half     = cfg.success_half_period;
				limit    = cfg.success_blinks;
			end
			slbs_pkg::ST_ERROR: begin
				blinking = 1'b1;
				counted  = 1'b1;
				half     = cfg.error_half_period;
				limit    = cfg.error_blinks;
			end
			slbs_pkg::ST_CONFIG: begin
				blinking = 1'b1;
				half     = cfg.config_half_period;
			end
			default: ;
		endcase

		if (req.action) begin
			// unknown codes and the mode already running are ignored
			if (req.requested_mode <= slbs_pkg::MODE_CONFIG && req_mode != mode_q) begin
				mode_n    = req_mode;
				elapsed_n = '0;
				opc_n     = '0;
				phase_n   = 1'b1;
				if (cfg.led_enabled) begin
					color_n = slbs_pkg::scale_rgb(slbs_pkg::mode_rgb(req_mode), cfg.brightness);
					written = 1'b1;
				end
			end
		end else if (cfg.led_enabled && blinking) begin
			if (slbs_pkg::CMP_W'(inc_cnt) >= slbs_pkg::CMP_W'(half)) begin
				phase_n   = ~phase_q;
				elapsed_n = '0;
				written   = 1'b1;
				if (phase_n) begin
					color_n = slbs_pkg::scale_rgb(slbs_pkg::mode_rgb(mode_q), cfg.brightness);
				end else begin
					color_n = slbs_pkg::RGB_OFF;
					if (counted && opc_q != slbs_pkg::BLINK_MAX) begin
						opc_n = opc_q + 1'b1;
					end
				end
				// blink budget spent: drop back to idle, LED off
				if (counted && opc_n >= limit) begin
					mode_n  = slbs_pkg::ST_IDLE;
					opc_n   = '0;
					phase_n = 1'b1;
					color_n = slbs_pkg::RGB_OFF;
				end
			end else begin
				elapsed_n = inc_cnt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= slbs_pkg::ST_IDLE;
			elapsed_q <= '0;
			phase_q   <= 1'b0;
			opc_q     <= '0;
			color_q   <= '0;
		end else if (fire) begin
			mode_q    <= mode_n;
			elapsed_q <= elapsed_n;
			phase_q   <= phase_n;
			opc_q     <= opc_n;
			color_q   <= color_n;
		end
	end

	always_comb begin
		rsp.red           = color_n[23:16];
		rsp.green         = color_n[15:8];
		rsp.blue          = color_n[7:0];
		rsp.color_written = written;
		rsp.current_mode  = slbs_pkg::mode_code(mode_n);
	end

endmodule

>>> rtl/status_led_blink_sequencer.sv
// Status LED sequencer for one RGB pixel.
// Request channel (req_valid / req_stall / req): each word is either a
// one-millisecond tick (action = 0) or a mode request (action = 1).
// Response channel (rsp_valid / rsp_stall / rsp): exactly one word per
// request word, in order, carrying the pixel colour, a flag telling whether
// that word wrote a new colour, and the mode after it.
// Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): ready is
// always high; write registers only while no word is in flight.
// An accepted word is registered in the input register, processed by the
// core update step and registered in the response register, which drives
// rsp. Throughput is one word per cycle while rsp_stall is low; the single
// update step between the input and response registers sets that rate.
// When rsp_stall is high while a response is valid, the response register
// holds; if the input register is empty, one more word is taken into it,
// then req_stall rises until the response is taken.
// Reset clears both pipeline stages, returns to idle with the LED off and
// loads the config registers with their defaults (disabled, brightness 30).
module status_led_blink_sequencer (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_stall,
	input  slbs_pkg::req_t             req,
	output logic                       rsp_valid,
	input  logic                       rsp_stall,
	output slbs_pkg::rsp_t             rsp,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [2:0]                 cfg_index,
	input  logic [slbs_pkg::CFG_W-1:0] cfg_data
);

	slbs_pkg::cfg_t cfg_q;
	slbs_pkg::req_t req_s1;
	logic           valid_s1;
	slbs_pkg::rsp_t rsp_s2, core_rsp;
	logic           rsp_valid_s2;
	logic           out_free, adv;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.led_enabled         <= 1'b0;
			cfg_q.brightness          <= 8'd30;
			cfg_q.sync_half_period    <= slbs_pkg::HALF_W'(500);
			cfg_q.success_half_period <= slbs_pkg::HALF_W'(500);
			cfg_q.error_half_period   <= slbs_pkg::HALF_W'(300);
			cfg_q.config_half_period  <= slbs_pkg::HALF_W'(200);
			cfg_q.success_blinks      <= slbs_pkg::BLINK_W'(2);
			cfg_q.error_blinks        <= slbs_pkg::BLINK_W'(3);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				slbs_pkg::REG_LED_ENABLED:    cfg_q.led_enabled <= cfg_data[0];
				slbs_pkg::REG_BRIGHTNESS:     cfg_q.brightness <= cfg_data[7:0];
				slbs_pkg::REG_SYNC_HALF:      cfg_q.sync_half_period <= cfg_data;
				slbs_pkg::REG_SUCCESS_HALF:   cfg_q.success_half_period <= cfg_data;
				slbs_pkg::REG_ERROR_HALF:     cfg_q.error_half_period <= cfg_data;
				slbs_pkg::REG_CONFIG_HALF:    cfg_q.config_half_period <= cfg_data;
				slbs_pkg::REG_SUCCESS_BLINKS: begin
					cfg_q.success_blinks <= cfg_data[slbs_pkg::BLINK_W-1:0];
				end
				slbs_pkg::REG_ERROR_BLINKS: begin
					cfg_q.error_blinks <= cfg_data[slbs_pkg::BLINK_W-1:0];
				end
			endcase
		end
	end

	// response register empty or being drained this cycle
	assign out_free  = !rsp_valid_s2 || !rsp_stall;
	assign adv       = valid_s1 && out_free;
	assign req_stall = valid_s1 && !out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!req_stall && req_valid) begin
			req_s1 <= req;
		end
	end

	slbs_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (adv),
		.req    (req_s1),
		.cfg    (cfg_q),
		.rsp    (core_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_s2 <= 1'b0;
		end else if (out_free) begin
			rsp_valid_s2 <= adv;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rsp_s2 <= core_rsp;
		end
	end

	assign rsp_valid = rsp_valid_s2;
	assign rsp       = rsp_s2;

endmodule

>>> rtl/slbs_checker.sv
`include "status_led_blink_sequencer_macros.svh"

module slbs_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           rsp_valid,
	input logic           rsp_stall,
	input slbs_pkg::rsp_t rsp
);

	`SLBS_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "response word changed while stalled")

	`SLBS_ASSERT_NOW(a_mode_range, clk, arst_n, rsp_valid, rsp.current_mode <= slbs_pkg::MODE_CONFIG, "current_mode out of range")

	// a write that lands in idle always turns the pixel off
	`SLBS_ASSERT_NOW(a_idle_dark, clk, arst_n, rsp_valid && rsp.color_written && rsp.current_mode == slbs_pkg::MODE_IDLE, rsp.red == 8'd0 && rsp.green == 8'd0 && rsp.blue == 8'd0, "idle write not dark")

	// success only ever shows green or off
	`SLBS_ASSERT_NOW(a_success_green, clk, arst_n, rsp_valid && rsp.color_written && rsp.current_mode == slbs_pkg::MODE_SUCCESS, rsp.red == 8'd0 && rsp.blue == 8'd0, "success write not green")

endmodule

bind status_led_blink_sequencer slbs_checker u_slbs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

>>> sim/status_led_blink_sequencer_tb.sv
`timescale 1ns / 100ps

module status_led_blink_sequencer_tb;
	import slbs_pkg::*;

	localparam logic ACT_TICK = 1'b0;
	localparam logic ACT_MODE = 1'b1;
	// codes past config, which the block must ignore
	localparam logic [2:0] MODE_RSVD_A = 3'd6;
	localparam logic [2:0] MODE_RSVD_B = 3'd7;
	localparam int QUIET_LIMIT = 2000;

	logic clk;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;

	status_led_blink_sequencer u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// sequencer state as the testbench sees it
	cfg_t m_cfg;
	logic [2:0] m_mode;
	logic [TICK_W-1:0] m_elapsed;
	logic m_phase;
	logic [BLINK_W-1:0] m_off;
	logic [23:0] m_shown;

	req_t words_to_send[$];
	rsp_t pixel_words_due[$];

	int mismatches = 0;
	int words_in = 0;
	int words_out = 0;
	int color_writes = 0;
	int reg_loads = 0;
	int quiet_cycles = 0;

	bit sender_pauses = 1'b1;
	bit receiver_pauses = 1'b1;
	int burst_left = 0;
	int gap_left = 0;
	int hold_left = 0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic [23:0] lit_color(input logic [2:0] m);
		case (m)
			MODE_SYNC:    return RGB_ORANGE;
			MODE_UNCONF:  return RGB_YELLOW;
			MODE_SUCCESS: return RGB_GREEN;
			MODE_ERROR:   return RGB_RED;
			MODE_CONFIG:  return RGB_WHITE;
			default:      return RGB_OFF;
		endcase
	endfunction

	function automatic logic [7:0] dim(input logic [7:0] c);
		return 8'((int'(c) * int'(m_cfg.brightness)) / 255);
	endfunction

	function automatic logic paint(input logic [23:0] rgb);
		if (!m_cfg.led_enabled) begin
			return 1'b0;
		end
		m_shown = {dim(rgb[23:16]), dim(rgb[15:8]), dim(rgb[7:0])};
		return 1'b1;
	endfunction

	function automatic logic switch_mode(input logic [2:0] m);
		m_mode = m;
		m_elapsed = '0;
		m_off = '0;
		m_phase = 1'b1;
		return paint(lit_color(m));
	endfunction

	function automatic rsp_t next_pixel_word(input req_t w);
		rsp_t o;
		logic wrote;
		logic counted;
		logic [HALF_W-1:0] half;
		logic [BLINK_W-1:0] lim;
		wrote = 1'b0;
		half = '0;
		lim = '0;
		counted = (m_mode == MODE_SUCCESS) || (m_mode == MODE_ERROR);
		if (w.action == ACT_MODE) begin
			if (w.requested_mode <= MODE_CONFIG && w.requested_mode != m_mode) begin
				wrote = switch_mode(w.requested_mode);
			end
		end else if (m_cfg.led_enabled && m_mode != MODE_IDLE && m_mode != MODE_UNCONF
				&& m_mode <= MODE_CONFIG) begin
			case (m_mode)
				MODE_SYNC: begin
					half = m_cfg.sync_half_period;
				end
				MODE_SUCCESS: begin
					half = m_cfg.success_half_period;
					lim = m_cfg.success_blinks;
				end
				MODE_ERROR: begin
					half = m_cfg.error_half_period;
					lim = m_cfg.error_blinks;
				end
				default: begin
					half = m_cfg.config_half_period;
				end
			endcase
			if (m_elapsed != TICK_MAX) begin
				m_elapsed = m_elapsed + 1'b1;
			end
			if (m_elapsed >= half) begin
				m_phase = ~m_phase;
				if (m_phase) begin
					wrote = paint(lit_color(m_mode));
				end else begin
					wrote = paint(RGB_OFF);
					if (counted && m_off != BLINK_MAX) begin
						m_off = m_off + 1'b1;
					end
				end
				m_elapsed = '0;
				if (counted && m_off >= lim) begin
					wrote |= switch_mode(MODE_IDLE);
				end
			end
		end
		o.red = m_shown[23:16];
		o.green = m_shown[15:8];
		o.blue = m_shown[7:0];
		o.color_written = wrote;
		o.current_mode = m_mode;
		return o;
	endfunction

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	task automatic queue_word(input logic act, input logic [2:0] m);
		req_t w;
		w.action = act;
		w.requested_mode = m;
		words_to_send.push_back(w);
	endtask

	// mode field of a tick is don't-care, so fill it with junk
	task automatic queue_ticks(input int n);
		repeat (n) queue_word(ACT_TICK, 3'($urandom));
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (words_to_send.size() != 0 || req_valid || pixel_words_due.size() != 0);
		repeat (2) @(negedge clk);
	endtask

	task automatic load_settings(input cfg_t c);
		logic [15:0] d;
		logic [2:0] ix;
		@(posedge clk);
		for (int i = 0; i < 8; i++) begin
			ix = 3'(i);
			d = 16'($urandom);	// unused upper bits of narrow registers get junk
			case (ix)
				REG_LED_ENABLED:    d[0] = c.led_enabled;
				REG_BRIGHTNESS:     d[7:0] = c.brightness;
				REG_SYNC_HALF:      d = c.sync_half_period;
				REG_SUCCESS_HALF:   d = c.success_half_period;
				REG_ERROR_HALF:     d = c.error_half_period;
				REG_CONFIG_HALF:    d = c.config_half_period;
				REG_SUCCESS_BLINKS: d[3:0] = c.success_blinks;
				default:            d[3:0] = c.error_blinks;
			endcase
			cfg_valid <= 1'b1;
			cfg_index <= ix;
			cfg_data <= d;
			do @(posedge clk);
			while (!cfg_ready);
			case (ix)
				REG_LED_ENABLED:    m_cfg.led_enabled = d[0];
				REG_BRIGHTNESS:     m_cfg.brightness = d[7:0];
				REG_SYNC_HALF:      m_cfg.sync_half_period = d;
				REG_SUCCESS_HALF:   m_cfg.success_half_period = d;
				REG_ERROR_HALF:     m_cfg.error_half_period = d;
				REG_CONFIG_HALF:    m_cfg.config_half_period = d;
				REG_SUCCESS_BLINKS: m_cfg.success_blinks = d[3:0];
				default:            m_cfg.error_blinks = d[3:0];
			endcase
		end
		cfg_valid <= 1'b0;
		reg_loads++;
	endtask

	// mostly short periods so blinks and returns to idle happen often
	function automatic logic [15:0] pick_half();
		case ($urandom_range(0, 9))
			0:       return 16'd0;
			1:       return 16'hFFFF;
			2:       return 16'($urandom);
			default: return 16'($urandom_range(1, 10));
		endcase
	endfunction

	function automatic cfg_t random_settings();
		cfg_t c;
		c.led_enabled = ($urandom_range(0, 5) != 0);
		case ($urandom_range(0, 4))
			0:       c.brightness = 8'd0;
			1:       c.brightness = 8'd255;
			2:       c.brightness = 8'd128;
			default: c.brightness = 8'($urandom);
		endcase
		c.sync_half_period = pick_half();
		c.success_half_period = pick_half();
		c.error_half_period = pick_half();
		c.config_half_period = pick_half();
		c.success_blinks = 4'($urandom);
		c.error_blinks = 4'($urandom);
		return c;
	endfunction

	// sender: bursts of random length, with random gaps when sender_pauses is set
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else if (!req_valid || !req_stall) begin
			if (gap_left > 0) begin
				gap_left--;
				req_valid <= 1'b0;
			end else if (words_to_send.size() != 0) begin
				req <= words_to_send.pop_front();
				req_valid <= 1'b1;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(0, 20);
					gap_left = sender_pauses ? $urandom_range(1, 5) : 0;
				end
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// receiver: alternating runs of free and stalled cycles, never stalled when receiver_pauses is clear
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
		end else if (rsp_stall || !receiver_pauses) begin
			rsp_stall <= 1'b0;
			hold_left = $urandom_range(0, 12);
		end else begin
			rsp_stall <= 1'b1;
			hold_left = $urandom_range(0, 6);
		end
	end

	// check the response word first: it always belongs to an earlier request word
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				words_out++;
				if (pixel_words_due.size() == 0) begin
					$error("response word with nothing expected");
					mismatches++;
				end else begin
					want = pixel_words_due.pop_front();
					check_field("red", want.red, rsp.red);
					check_field("green", want.green, rsp.green);
					check_field("blue", want.blue, rsp.blue);
					check_field("color_written", 8'(want.color_written),
						8'(rsp.color_written));
					check_field("current_mode", 8'(want.current_mode),
						8'(rsp.current_mode));
				end
			end
			if (req_valid && !req_stall) begin
				want = next_pixel_word(req);
				if (want.color_written) begin
					color_writes++;
				end
				pixel_words_due.push_back(want);
				words_in++;
			end
		end
	end

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
		$display("timeout: %0d cycles without a handshake", QUIET_LIMIT);
		$display("FAIL status_led_blink_sequencer");
		$finish;
	end

	initial begin
		cfg_t c;
		int n;
		int len;
		m_cfg = '{led_enabled: 1'b0, brightness: 8'd30, sync_half_period: 16'd500,
			success_half_period: 16'd500, error_half_period: 16'd300,
			config_half_period: 16'd200, success_blinks: 4'd2, error_blinks: 4'd3};
		m_mode = MODE_IDLE;
		m_elapsed = '0;
		m_phase = 1'b0;
		m_off = '0;
		m_shown = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// reset defaults leave the LED disabled: mode moves, nothing is written
		queue_word(ACT_MODE, MODE_SYNC);
		queue_ticks(1);
		queue_word(ACT_MODE, MODE_SYNC);
		wait_drained();

		c = '{led_enabled: 1'b1, brightness: 8'd255, sync_half_period: 16'd1,
			success_half_period: 16'd2, error_half_period: 16'd1,
			config_half_period: 16'd0, success_blinks: 4'd1, error_blinks: 4'd0};
		load_settings(c);
		queue_word(ACT_MODE, MODE_SYNC);	// already in sync
		queue_ticks(2);
		queue_word(ACT_MODE, MODE_UNCONF);
		queue_ticks(1);
		queue_word(ACT_MODE, MODE_SUCCESS);
		queue_ticks(2);
		queue_word(ACT_MODE, MODE_ERROR);	// blink limit zero
		queue_ticks(1);
		queue_word(ACT_MODE, MODE_CONFIG);	// zero half period
		queue_ticks(2);
		queue_word(ACT_MODE, MODE_RSVD_A);
		queue_word(ACT_MODE, MODE_RSVD_B);
		queue_word(ACT_MODE, MODE_IDLE);
		queue_ticks(1);
		queue_word(ACT_MODE, MODE_CONFIG);
		queue_word(ACT_MODE, MODE_SUCCESS);
		queue_ticks(1);
		wait_drained();

		// longer half period: one full off and on phase, words back to back
		sender_pauses = 1'b0;
		receiver_pauses = 1'b0;
		c.brightness = 8'd128;
		c.sync_half_period = 16'd250;
		load_settings(c);
		queue_word(ACT_MODE, MODE_SYNC);
		queue_ticks(500);
		queue_word(ACT_MODE, MODE_IDLE);
		wait_drained();

		for (int p = 0; p < 8; p++) begin
			sender_pauses = ($urandom_range(0, 3) != 0);
			receiver_pauses = ($urandom_range(0, 3) != 0);
			load_settings(random_settings());
			n = 0;
			while (n < 200) begin
				if ($urandom_range(0, 4) != 0) begin
					queue_word(ACT_MODE, 3'($urandom_range(MODE_IDLE, MODE_CONFIG)));
					len = $urandom_range(1, 40);
					queue_ticks(len);
					n += len + 1;
				end else begin
					queue_word(1'($urandom), 3'($urandom));
					n++;
				end
			end
			wait_drained();
		end

		repeat (4) @(posedge clk);
		$display("%0d words sent, %0d responses checked, %0d color writes predicted",
			words_in, words_out, color_writes);
		$display("%0d register loads across directed, long-period and random settings",
			reg_loads);
		if (mismatches == 0 && pixel_words_due.size() == 0) begin
			$display("PASS status_led_blink_sequencer");
		end else begin
			$display("FAIL status_led_blink_sequencer");
		end
		$finish;
	end

endmodule

>>> filelist.f
+incdir+rtl
rtl/slbs_pkg.sv
rtl/slbs_core.sv
rtl/status_led_blink_sequencer.sv
rtl/slbs_checker.sv
sim/status_led_blink_sequencer_tb.sv
